[rtl/assert_macros.svh]
// assertion macros used by ius2x_ctrl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication, disabled in reset
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

[rtl/ius2x_pkg.sv]
// shared types and constants for the 2x upscaler
// no dependencies
package ius2x_pkg;

    localparam int MAX_SIDE_DEF = 64;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [6:0] DIM_RESET = 7'd64;

    typedef struct packed {
        logic       opcode;
        logic [6:0] row;
        logic [6:0] column;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } t_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       out_of_range;
    } t_out;

    typedef struct packed {
        logic       load;
        logic       cap;
        logic       rd_en;
        logic [1:0] rd_row;
        logic [1:0] rd_col;
        logic       vs_en;
        logic       ci_en;
        logic       out_ld;
    } t_cmd;

    typedef struct packed {
        logic oor;
        logic out_free;
    } t_sts;

endpackage

[rtl/ius2x_ctrl.sv]
// sequencer for loads and upscaled reads
// depends on ius2x_pkg and assert_macros.svh
`include "assert_macros.svh"

module ius2x_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_opcode,
    output logic              o_ready,
    input  ius2x_pkg::t_sts   i_sts,
    output ius2x_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_VS    = 3'd4;
    localparam logic [2:0] S_CI    = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_fr, n_fr;
    logic [1:0] r_fc, n_fc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fr    <= 2'd0;
            r_fc    <= 2'd0;
        end else begin
            r_state <= n_state;
            r_fr    <= n_fr;
            r_fc    <= n_fc;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fr    = r_fr;
        n_fc    = r_fc;
        o_cmd   = '0;
        o_cmd.rd_row = r_fr;
        o_cmd.rd_col = r_fc;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_opcode == ius2x_pkg::OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.cap = 1'b1;
                        n_state   = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_fr = 2'd0;
                n_fc = 2'd0;
                n_state = i_sts.oor ? S_DONE : S_FETCH;
            end
            S_FETCH: begin
                o_cmd.rd_en = 1'b1;
                if (r_fc == 2'd2) begin
                    n_fc = 2'd0;
                    if (r_fr == 2'd2) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_fr = r_fr + 2'd1;
                    end
                end else begin
                    n_fc = r_fc + 2'd1;
                end
            end
            S_DRAIN: begin
                n_state = S_VS;
            end
            S_VS: begin
                o_cmd.vs_en = 1'b1;
                n_state = S_CI;
            end
            S_CI: begin
                o_cmd.ci_en = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `CHK_IMPL(a_ld_free, i_clk, i_rst_n, o_cmd.out_ld, i_sts.out_free)
    `CHK_IMPL(a_fetch_cnt, i_clk, i_rst_n, r_state == S_FETCH, r_fr != 2'd3 && r_fc != 2'd3)
    `CHK_NEXT(a_read_check, i_clk, i_rst_n, o_cmd.cap, r_state == S_CHECK)

endmodule

[rtl/ius2x_dp.sv]
// frame memory, pixel window and filter arithmetic
// depends on ius2x_pkg
module ius2x_dp #(
    parameter int MAX_SIDE = ius2x_pkg::MAX_SIDE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ius2x_pkg::t_cmd   i_cmd,
    input  ius2x_pkg::t_in    i_data,
    input  logic [6:0]        i_width,
    input  logic [6:0]        i_height,
    output ius2x_pkg::t_sts   o_sts,
    output logic              o_valid,
    input  logic              i_ready,
    output ius2x_pkg::t_out   o_data
);

    localparam int MEM_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW        = $clog2(MEM_DEPTH);

    typedef struct packed {
        logic [1:0] c;
        logic [1:0] n;
    } t_tap;
    typedef t_tap [2:0] t_taps;

    function automatic logic [6:0] eff_dim(input logic [6:0] r);
        return (r == 7'd0) ? 7'd1 : ((32'(r) > MAX_SIDE) ? 7'(MAX_SIDE) : r);
    endfunction

    function automatic logic [6:0] win_idx(input logic [5:0] k, input logic [1:0] j,
                                           input logic [6:0] dim);
        logic [6:0] t;
        logic [6:0] v;
        t = {1'b0, k} + 7'(j);
        v = (t == 7'd0) ? 7'd0 : t - 7'd1;
        return (v > dim - 7'd1) ? dim - 7'd1 : v;
    endfunction

    function automatic t_taps taps(input logic [6:0] p, input logic [6:0] dim);
        t_taps t;
        logic  last;
        last = ({1'b0, p} == ({dim, 1'b0} - 8'd1));
        if (!p[0]) begin
            t[0] = (p == 7'd0) ? t_tap'{c: 2'd1, n: 2'd0} : t_tap'{c: 2'd0, n: 2'd1};
            t[1] = t_tap'{c: 2'd1, n: 2'd0};
            t[2] = t_tap'{c: 2'd1, n: 2'd2};
        end else begin
            t[0] = t_tap'{c: 2'd1, n: 2'd0};
            t[1] = t_tap'{c: 2'd1, n: 2'd2};
            t[2] = last ? t_tap'{c: 2'd1, n: 2'd2} : t_tap'{c: 2'd2, n: 2'd1};
        end
        return t;
    endfunction

    logic [31:0] mem [MEM_DEPTH];
    logic [31:0] r_rd_data;
    logic        r_rd_vld;
    logic [3:0]  r_rd_slot;
    logic [31:0] r_win [9];
    logic [6:0]  r_y, r_x;
    logic [12:0] r_vs [3][4];
    logic [12:0] n_vs [3][4];
    logic [14:0] r_ci [3][4];
    logic [14:0] n_ci [3][4];
    ius2x_pkg::t_out r_out, n_out;
    logic        r_out_valid;

    logic [6:0]  h, w;
    logic        wr_ok;
    logic [AW-1:0] wa, ra;
    logic [6:0]  ri, cix;
    t_taps       rt, ct;
    logic [9:0]  rv [3];
    logic [12:0] pos_v;
    logic [10:0] neg_v;
    logic [17:0] pos_o;
    logic [15:0] neg_o;
    logic [17:0] d_o;
    logic [10:0] rnd;
    logic [7:0]  ch_val [4];

    assign h = eff_dim(i_height);
    assign w = eff_dim(i_width);

    assign wr_ok = (32'(i_data.row) < MAX_SIDE) && (32'(i_data.column) < MAX_SIDE);
    assign wa = AW'(32'(i_data.row) * MAX_SIDE + 32'(i_data.column));
    assign ri  = win_idx(r_y[6:1], i_cmd.rd_row, h);
    assign cix = win_idx(r_x[6:1], i_cmd.rd_col, w);
    assign ra = AW'(32'(ri) * MAX_SIDE + 32'(cix));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wr_ok) begin
            mem[wa] <= {i_data.alpha_in, i_data.blue_in, i_data.green_in, i_data.red_in};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_slot <= {1'b0, i_cmd.rd_row, 1'b0} + 4'(i_cmd.rd_row) + 4'(i_cmd.rd_col);
        if (r_rd_vld) begin
            r_win[r_rd_slot] <= r_rd_data;
        end
        if (i_cmd.cap) begin
            r_y <= i_data.row;
            r_x <= i_data.column;
        end
        if (i_cmd.vs_en) begin
            r_vs <= n_vs;
        end
        if (i_cmd.ci_en) begin
            r_ci <= n_ci;
        end
        if (i_cmd.out_ld) begin
            r_out <= n_out;
        end
    end

    // vertical interpolation and sharpen, per source column of the window
    always_comb begin
        rt = taps(r_y, h);
        for (int j = 0; j < 3; j++) begin
            for (int ch = 0; ch < 4; ch++) begin
                for (int o = 0; o < 3; o++) begin
                    rv[o] = 10'(r_win[4'(3 * int'(rt[o].n) + j)][8 * ch +: 8])
                          + 10'(r_win[4'(3 * int'(rt[o].c) + j)][8 * ch +: 8]) * 10'd3;
                end
                pos_v = 13'(rv[1]) * 13'd6;
                neg_v = 11'(rv[0]) + 11'(rv[2]);
                n_vs[j][ch] = (pos_v > 13'(neg_v)) ? pos_v - 13'(neg_v) : 13'd0;
            end
        end
    end

    // horizontal interpolation
    always_comb begin
        ct = taps(r_x, w);
        for (int o = 0; o < 3; o++) begin
            for (int ch = 0; ch < 4; ch++) begin
                n_ci[o][ch] = 15'(r_vs[ct[o].n][ch]) + 15'(r_vs[ct[o].c][ch]) * 15'd3;
            end
        end
    end

    // horizontal sharpen, rounding and clamp
    always_comb begin
        for (int ch = 0; ch < 4; ch++) begin
            pos_o = 18'(r_ci[1][ch]) * 18'd6;
            neg_o = 16'(r_ci[0][ch]) + 16'(r_ci[2][ch]);
            d_o   = (pos_o > 18'(neg_o)) ? pos_o - 18'(neg_o) : 18'd0;
            rnd   = 11'((19'(d_o) + 19'd128) >> 8);
            ch_val[ch] = (rnd > 11'd255) ? 8'd255 : rnd[7:0];
        end
        n_out = '0;
        if (o_sts.oor) begin
            n_out.out_of_range = 1'b1;
        end else begin
            n_out.red_out   = ch_val[0];
            n_out.green_out = ch_val[1];
            n_out.blue_out  = ch_val[2];
            n_out.alpha_out = ch_val[3];
        end
    end

    assign o_sts.oor = ({1'b0, r_y} >= {h, 1'b0}) || ({1'b0, r_x} >= {w, 1'b0});
    assign o_sts.out_free = !r_out_valid || i_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[rtl/image_upscale_2x_sharpen.sv]
// A load transfer writes one RGBA source pixel into the frame memory when it is accepted;
// loads outside the memory are dropped. A read transfer returns one pixel of the doubled,
// sharpened frame; from its acceptance to the next acceptance the block steps through a
// range check, nine window reads at one per cycle through the single read port of the
// frame memory, a drain state for the read latency, two filter stages and the output load.
// A read outside the doubled frame skips the window and goes straight to the output load.
// The output load waits while an earlier result is still held; the next item is taken
// while the result waits in the output register. Frame memory is not cleared at reset;
// pixels must be loaded before they are read. Dimensions are written over the APB port.
// depends on ius2x_pkg, ius2x_ctrl and ius2x_dp
module image_upscale_2x_sharpen #(
    parameter int MAX_SIDE = ius2x_pkg::MAX_SIDE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ius2x_pkg::t_in   i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output ius2x_pkg::t_out  o_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [6:0] r_width, r_height;
    ius2x_pkg::t_cmd cmd;
    ius2x_pkg::t_sts sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ius2x_pkg::DIM_RESET;
            r_height <= ius2x_pkg::DIM_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                ius2x_pkg::REG_WIDTH:  r_width  <= pwdata[6:0];
                ius2x_pkg::REG_HEIGHT: r_height <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            ius2x_pkg::REG_WIDTH:  prdata = {25'd0, r_width};
            ius2x_pkg::REG_HEIGHT: prdata = {25'd0, r_height};
            default:               prdata = 32'd0;
        endcase
    end

    ius2x_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_data.opcode),
        .o_ready  (o_ready),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    ius2x_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_data   (i_data),
        .i_width  (r_width),
        .i_height (r_height),
        .o_sts    (sts),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );

endmodule
